>>> rtl/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // operation codes
    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_REM = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_QUEUED   = 3'd0;
    localparam logic [2:0] STAT_SERVED   = 3'd1;
    localparam logic [2:0] STAT_REMOVED  = 3'd2;
    localparam logic [2:0] STAT_EMPTY    = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;
    localparam logic [2:0] STAT_FULL     = 3'd5;
    localparam logic [2:0] STAT_BADLEVEL = 3'd6;

    localparam logic [1:0] LEVEL_NONE = 2'd0;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] user_key;
        logic [1:0]  prio_level;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] served_key;
        logic [1:0]  served_level;
    } out_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [1:0]          level;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic [CNT_W-1:0] occ;
    } ctrl_stat_t;

endpackage

>>> rtl/spq_mem.sv
module spq_mem
    import spq_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem_arr [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_arr[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem_arr[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/spq_ctrl.sv
module spq_ctrl
    import spq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  in_t        cmd,
    input  logic       take,
    input  entry_t     rd_data,
    output mem_req_t   mem_req,
    output ctrl_stat_t stat,
    output out_t       result
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ENQ  = 5'b00010,
        S_PUT  = 5'b00100,
        S_DEL  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [1:0]          lvl_reg, lvl_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                found_reg, found_next;
    out_t                res_reg, res_next;

    logic   hit;
    logic   last;
    entry_t new_entry;

    assign new_entry = '{key: key_reg, level: lvl_reg};
    assign hit  = !found_reg && ((op_reg == OP_DEQ) || (rd_data.key == key_reg));
    assign last = ({1'b0, idx_reg} == (occ_reg - CNT_W'(1)));

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        lvl_next   = lvl_reg;
        occ_next   = occ_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        res_next   = res_reg;
        mem_req    = '0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    op_next    = cmd.op;
                    key_next   = KEY_BITS'(cmd.user_key);
                    lvl_next   = cmd.prio_level;
                    found_next = 1'b0;
                    res_next   = '{status: STAT_NOTFOUND, served_key: '0, served_level: '0};
                    state_next = S_FIN;
                    case (cmd.op)
                        OP_ENQ: begin
                            if (cmd.prio_level == LEVEL_NONE) begin
                                res_next.status = STAT_BADLEVEL;
                            end else if (occ_reg == CNT_W'(CAPACITY)) begin
                                res_next.status = STAT_FULL;
                            end else if (occ_reg == '0) begin
                                mem_req.we      = 1'b1;
                                mem_req.waddr   = '0;
                                mem_req.wdata   = '{key: KEY_BITS'(cmd.user_key),
                                                    level: cmd.prio_level};
                                occ_next        = occ_reg + CNT_W'(1);
                                res_next.status = STAT_QUEUED;
                            end else begin
                                // walk down from the tail
                                mem_req.raddr = IDX_W'(occ_reg - CNT_W'(1));
                                idx_next      = IDX_W'(occ_reg - CNT_W'(1));
                                state_next    = S_ENQ;
                            end
                        end
                        OP_DEQ, OP_REM: begin
                            if (occ_reg == '0) begin
                                res_next.status = STAT_EMPTY;
                            end else begin
                                mem_req.raddr = '0;
                                idx_next      = '0;
                                state_next    = S_DEL;
                            end
                        end
                        default: begin
                            res_next.status = STAT_NOTFOUND;
                        end
                    endcase
                end
            end

            S_ENQ: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg + IDX_W'(1);
                if (rd_data.level < lvl_reg) begin
                    // move the lower-level entry one slot back
                    mem_req.wdata = rd_data;
                    if (idx_reg == '0) begin
                        state_next = S_PUT;
                    end else begin
                        mem_req.raddr = idx_reg - IDX_W'(1);
                        idx_next      = idx_reg - IDX_W'(1);
                    end
                end else begin
                    mem_req.wdata   = new_entry;
                    occ_next        = occ_reg + CNT_W'(1);
                    res_next.status = STAT_QUEUED;
                    state_next      = S_FIN;
                end
            end

            S_PUT: begin
                mem_req.we      = 1'b1;
                mem_req.waddr   = idx_reg;
                mem_req.wdata   = new_entry;
                occ_next        = occ_reg + CNT_W'(1);
                res_next.status = STAT_QUEUED;
                state_next      = S_FIN;
            end

            S_DEL: begin
                if (found_reg) begin
                    // close the gap
                    mem_req.we    = 1'b1;
                    mem_req.waddr = idx_reg - IDX_W'(1);
                    mem_req.wdata = rd_data;
                end
                if (hit) begin
                    found_next = 1'b1;
                    if (op_reg == OP_DEQ) begin
                        res_next.served_key   = 32'(rd_data.key);
                        res_next.served_level = rd_data.level;
                    end
                end
                if (last) begin
                    if (found_reg || hit) begin
                        occ_next        = occ_reg - CNT_W'(1);
                        res_next.status = (op_reg == OP_DEQ) ? STAT_SERVED : STAT_REMOVED;
                    end else begin
                        res_next.status = STAT_NOTFOUND;
                    end
                    state_next = S_FIN;
                end else begin
                    mem_req.raddr = idx_reg + IDX_W'(1);
                    idx_next      = idx_reg + IDX_W'(1);
                end
            end

            S_FIN: begin
                if (take) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
        op_reg    <= op_next;
        key_reg   <= key_next;
        lvl_reg   <= lvl_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        res_reg   <= res_next;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_FIN);
    assign stat.occ  = occ_reg;
    assign result    = res_reg;

endmodule

>>> rtl/stable_priority_queue_with_removal.sv
// An accepted transaction that needs no memory pass goes straight to the finish state; one that
// walks the queue first steps through the entry memory, up to CAPACITY slots, then finishes.
// A new transaction is taken only after the last result has been handed over; the walk is a single
// read/write walk over the entry memory, one slot per cycle.
// Reset: synchronous, active low; empties the queue and drops any held result.
module stable_priority_queue_with_removal
    import spq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    mem_req_t   mem_req;
    entry_t     rd_data;
    ctrl_stat_t stat;
    out_t       result;
    logic       start;
    logic       take;

    out_t m_payload_reg, m_payload_next;
    logic m_valid_reg, m_valid_next;

    // The sequencer takes a new transaction only when it is idle; a finished
    // result may still wait in the output register meanwhile.
    assign s_ready = stat.idle;
    assign start   = s_valid && s_ready;

    // Hand the result over when the output register is free or being emptied.
    assign take = stat.done && (!m_valid_reg || m_ready);

    // Entry memory: entries are held in service order, slot 0 at the head.
    // The walk writes one slot behind (removal) or ahead (enqueue) of the slot
    // being read, so a read and a write never meet on the same entry.
    spq_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .cmd     (s_payload),
        .take    (take),
        .rd_data (rd_data),
        .mem_req (mem_req),
        .stat    (stat),
        .result  (result)
    );

    // Output register: load on hand-over, drop once the sink takes it.
    always_comb begin
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg;
        if (take) begin
            m_payload_next = result;
            m_valid_next   = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Occupancy never passes the capacity.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.occ <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    // Occupancy moves by at most one per cycle.
    a_occ_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown($past(stat.occ)) |->
        (stat.occ == $past(stat.occ) || stat.occ == $past(stat.occ) + CNT_W'(1)
         || stat.occ == $past(stat.occ) - CNT_W'(1)))
        else $error("occupancy jumped");

    // An accepted transaction keeps the sequencer busy in the next cycle.
    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready)
        else $error("sequencer idle after accept");

    // Served key and level are zero unless an entry was served.
    a_served_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status != STAT_SERVED) |->
        (m_payload.served_key == '0 && m_payload.served_level == '0))
        else $error("served fields set without service");

endmodule
